@@ sv/sqe_pkg.sv @@
// Shared types and codes for the stack/queue engine: request, command and result formats.
// No dependencies; the front end, back end, top level and checker import this package.
package sqe_pkg;

	// Request kinds as they arrive on the input port.
	localparam logic [2:0] REQ_PUSH  = 3'd0;
	localparam logic [2:0] REQ_PRINT = 3'd1;
	localparam logic [2:0] REQ_PEEK  = 3'd2;
	localparam logic [2:0] REQ_POP   = 3'd3;
	localparam logic [2:0] REQ_SWAP  = 3'd4;

	// Status codes carried by each result.
	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_BAD_ARG     = 3'd1;
	localparam logic [2:0] STAT_PEEK_EMPTY  = 3'd2;
	localparam logic [2:0] STAT_POP_EMPTY   = 3'd3;
	localparam logic [2:0] STAT_SWAP_SHORT  = 3'd4;
	localparam logic [2:0] STAT_FULL        = 3'd5;

	// Input transaction.
	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] push_value;
		logic               arg_ok;
	} sqe_req_t;

	// Result transaction.
	typedef struct packed {
		logic signed [31:0] data;
		logic               has_data;
		logic [2:0]         status;
		logic               last;
	} sqe_rsp_t;

	// Classified operations passed from the front end to the back end.
	typedef enum logic [2:0] {
		OP_PUSH,
		OP_BAD_ARG,
		OP_PRINT,
		OP_PEEK,
		OP_POP,
		OP_SWAP
	} sqe_op_t;

	typedef struct packed {
		sqe_op_t            op;
		logic signed [31:0] value;
	} sqe_cmd_t;

endpackage

@@ sv/sqe_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; a read sees the contents before a same-cycle write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/sqe_front.sv @@
// Front end of the stack/queue engine: accepts requests, classifies them and queues commands.
// Depends on sqe_pkg.
module sqe_front import sqe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  sqe_req_t req,
	output logic     busy,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output sqe_cmd_t cmd
);

	sqe_cmd_t   q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	sqe_cmd_t   new_cmd;
	logic       keep;
	logic       enq;
	logic       deq;

	// Classify the request; unused kinds are accepted and dropped.
	always_comb begin
		new_cmd.value = req.push_value;
		new_cmd.op    = OP_PUSH;
		keep          = 1'b1;
		case (req.req_type)
			REQ_PUSH:  new_cmd.op = req.arg_ok ? OP_PUSH : OP_BAD_ARG;
			REQ_PRINT: new_cmd.op = OP_PRINT;
			REQ_PEEK:  new_cmd.op = OP_PEEK;
			REQ_POP:   new_cmd.op = OP_POP;
			REQ_SWAP:  new_cmd.op = OP_SWAP;
			default:   keep = 1'b0;
		endcase
	end

	// Two-entry command queue toward the back end.
	assign busy      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rd_ptr_q];
	assign enq       = start && !busy && keep;
	assign deq       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

endmodule

@@ sv/sqe_back.sv @@
// Back end of the stack/queue engine: holds the store, the top pointer and the entry count,
// executes queued commands and drives the result register. Depends on sqe_pkg and sqe_ram.
module sqe_back import sqe_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_data,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  sqe_cmd_t cmd,
	output logic     rsp_valid,
	output sqe_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = AW + 2;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	typedef enum logic [4:0] {
		BK_IDLE    = 5'b00001,
		BK_PRINT   = 5'b00010,
		BK_SWAP_RD = 5'b00100,
		BK_SWAP_WA = 5'b01000,
		BK_SWAP_WB = 5'b10000
	} bk_state_t;

	bk_state_t      state_q, state_d;
	logic [AW-1:0]  top_q, top_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [AW-1:0]  ptr_q, ptr_d;
	logic [CW-1:0]  left_q, left_d;
	logic [31:0]    tmp_q;
	logic           push_at_top_q;
	logic           rd_vld_s1;
	logic           rd_last_s1;
	logic           rsp_valid_q;
	sqe_rsp_t       rsp_q;

	logic           we;
	logic [AW-1:0]  waddr;
	logic [31:0]    wdata;
	logic [AW-1:0]  raddr;
	logic [31:0]    rdata;
	logic           rd_issue;
	logic           rd_last;
	logic           emit;
	logic [2:0]     emit_status;
	logic           emit_last;

	// Slot one below the given one, wrapping at the bottom of the circular store.
	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
		return (s == '0) ? LAST_SLOT : s - AW'(1);
	endfunction

	// Slot one above the given one, wrapping at the top of the circular store.
	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + AW'(1);
	endfunction

	// Slot that lies k entries below s, for k below DEPTH.
	function automatic logic [AW-1:0] slot_below(input logic [AW-1:0] s, input logic [CW-1:0] k);
		logic [BW-1:0] t;
		logic [BW-1:0] c;
		logic [BW-1:0] r;
		t = BW'(s);
		c = BW'(k);
		r = (t >= c) ? (t - c) : (t + BW'(DEPTH) - c);
		return r[AW-1:0];
	endfunction

	sqe_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Command execution and sequencing of multi-cycle operations.
	always_comb begin
		state_d     = state_q;
		top_d       = top_q;
		cnt_d       = cnt_q;
		ptr_d       = ptr_q;
		left_d      = left_q;
		we          = 1'b0;
		waddr       = top_q;
		wdata       = cmd.value;
		raddr       = top_q;
		rd_issue    = 1'b0;
		rd_last     = 1'b0;
		emit        = 1'b0;
		emit_status = STAT_OK;
		emit_last   = 1'b1;
		cmd_ready   = (state_q == BK_IDLE) && !rd_vld_s1;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && cmd_ready) begin
					case (cmd.op)
						OP_PUSH: begin
							if (cnt_q == FULL_CNT) begin
								emit        = 1'b1;
								emit_status = STAT_FULL;
							end else begin
								we    = 1'b1;
								cnt_d = cnt_q + CW'(1);
								if (cnt_q == '0) begin
									waddr = top_q;
								end else if (push_at_top_q) begin
									waddr = slot_inc(top_q);
									top_d = slot_inc(top_q);
								end else begin
									waddr = slot_below(top_q, cnt_q);
								end
							end
						end
						OP_BAD_ARG: begin
							emit        = 1'b1;
							emit_status = STAT_BAD_ARG;
						end
						OP_PRINT: begin
							if (cnt_q == '0) begin
								emit = 1'b1;
							end else begin
								ptr_d   = top_q;
								left_d  = cnt_q;
								state_d = BK_PRINT;
							end
						end
						OP_PEEK: begin
							if (cnt_q == '0) begin
								emit        = 1'b1;
								emit_status = STAT_PEEK_EMPTY;
							end else begin
								raddr    = top_q;
								rd_issue = 1'b1;
								rd_last  = 1'b1;
							end
						end
						OP_POP: begin
							if (cnt_q == '0) begin
								emit        = 1'b1;
								emit_status = STAT_POP_EMPTY;
							end else begin
								if (cnt_q != CW'(1)) begin
									top_d = slot_dec(top_q);
								end
								cnt_d = cnt_q - CW'(1);
							end
						end
						OP_SWAP: begin
							if (cnt_q < CW'(2)) begin
								emit        = 1'b1;
								emit_status = STAT_SWAP_SHORT;
							end else begin
								raddr   = top_q;
								state_d = BK_SWAP_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			BK_PRINT: begin
				raddr    = ptr_q;
				rd_issue = 1'b1;
				rd_last  = (left_q == CW'(1));
				ptr_d    = slot_dec(ptr_q);
				left_d   = left_q - CW'(1);
				if (left_q == CW'(1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_SWAP_RD: begin
				// The top entry arrives now; fetch the one below it.
				raddr   = slot_dec(top_q);
				state_d = BK_SWAP_WA;
			end
			BK_SWAP_WA: begin
				we      = 1'b1;
				waddr   = top_q;
				wdata   = rdata;
				state_d = BK_SWAP_WB;
			end
			BK_SWAP_WB: begin
				we      = 1'b1;
				waddr   = slot_dec(top_q);
				wdata   = tmp_q;
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Hold the top entry while the swap completes.
	always_ff @(posedge clk) begin
		if (state_q == BK_SWAP_RD) begin
			tmp_q <= rdata;
		end
	end

	// Result register: store read data or a status-only result.
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			rsp_q.data     <= rdata;
			rsp_q.has_data <= 1'b1;
			rsp_q.status   <= STAT_OK;
			rsp_q.last     <= rd_last_s1;
		end else begin
			rsp_q.data     <= '0;
			rsp_q.has_data <= 1'b0;
			rsp_q.status   <= emit_status;
			rsp_q.last     <= emit_last;
		end
		rd_last_s1 <= rd_last;
	end

	// Control state, store pointers and the mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			top_q         <= '0;
			cnt_q         <= '0;
			ptr_q         <= '0;
			left_q        <= '0;
			push_at_top_q <= 1'b1;
			rd_vld_s1     <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			top_q       <= top_d;
			cnt_q       <= cnt_d;
			ptr_q       <= ptr_d;
			left_q      <= left_d;
			rd_vld_s1   <= rd_issue;
			rsp_valid_q <= rd_vld_s1 || emit;
			if (cfg_we) begin
				push_at_top_q <= cfg_data;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ sv/stack_queue_engine_unit.sv @@
// Stack/queue engine. A request is taken when start is high and busy is low; a two-entry
// command queue absorbs bursts. Swap reads two entries and writes them back in turn (one store
// read port and one write port), and print-all streams every entry, giving one result per cycle.
// The asynchronous reset empties the store and selects stack mode; the receiver cannot stall.
module stack_queue_engine_unit import sqe_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sqe_req_t req,
	input  logic     cfg_we,
	input  logic     cfg_data,
	output logic     rsp_valid,
	output sqe_rsp_t rsp
);

	logic     cmd_valid;
	logic     cmd_ready;
	sqe_cmd_t cmd;

	// Request intake and classification.
	sqe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Store and execution.
	sqe_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

@@ sv/sqe_checker.sv @@
// Port-level checks for the stack/queue engine and the bind that attaches them.
// Depends on sqe_pkg and on the ports of stack_queue_engine_unit.
module sqe_checker import sqe_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input sqe_req_t req,
	input logic     cfg_we,
	input logic     cfg_data,
	input logic     rsp_valid,
	input sqe_rsp_t rsp
);

	// A print stream has no gaps: a result that is not last is followed at once by another.
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |=> rsp_valid)
		else $error("print stream broke before its last result");

	// A result without data always ends its transaction.
	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_data |-> rsp.last)
		else $error("status-only result not marked last");

	// A result without data carries zero data.
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_data |-> rsp.data == '0)
		else $error("status-only result with nonzero data");

	// Data-carrying results always report success.
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.has_data |-> rsp.status == STAT_OK)
		else $error("data result with error status");

endmodule

bind stack_queue_engine_unit sqe_checker u_sqe_checker (.*);
